[rtl/lzss_pkg.sv]
// Package for the LZSS stream decompressor: default parameters, fixed field
// widths, the sequencer state type and the token status struct.
// No dependencies; every other file imports it.
package lzss_pkg;

  localparam int DEF_INDEX_BITS  = 12;
  localparam int DEF_LENGTH_BITS = 4;

  // Matches always copy at least this many bytes beyond one.
  localparam int MIN_MATCH_OFFSET = 1;
  localparam int END_MARKER       = 0;

  localparam int LIT_BITS = 8;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECODE = 4'b0010,
    S_READ   = 4'b0100,
    S_EMIT   = 4'b1000
  } lzss_state_t;

  typedef struct packed {
    logic lit_done;
    logic end_done;
    logic match_done;
  } lzss_tok_t;

endpackage

[rtl/lzss_if.sv]
// Stream interfaces for the decompressor: compressed bytes in, plain bytes out.
// Depends on lzss_pkg for the byte width.
interface lzss_code_if;
  import lzss_pkg::*;
  logic                valid;
  logic                ready;
  logic [LIT_BITS-1:0] in_byte;
  logic                new_stream;

  modport source (output valid, output in_byte, output new_stream, input ready);
  modport sink   (input valid, input in_byte, input new_stream, output ready);
endinterface

interface lzss_data_if;
  import lzss_pkg::*;
  logic                valid;
  logic                ready;
  logic [LIT_BITS-1:0] out_byte;
  logic                last_of_run;
  logic                stream_end;

  modport source (output valid, output out_byte, output last_of_run,
                  output stream_end, input ready);
  modport sink   (input valid, input out_byte, input last_of_run,
                  input stream_end, output ready);
endinterface

[rtl/lzss_window.sv]
// Circular history window: one write port and one registered read port.
// Depends on lzss_pkg for the byte width.
module lzss_window #(
  parameter int INDEX_BITS = lzss_pkg::DEF_INDEX_BITS
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [INDEX_BITS-1:0]         wr_addr,
  input  logic [lzss_pkg::LIT_BITS-1:0] wr_data,
  input  logic [INDEX_BITS-1:0]         rd_addr,
  output logic [lzss_pkg::LIT_BITS-1:0] rd_data
);
  import lzss_pkg::*;

  localparam int DEPTH = 1 << INDEX_BITS;

  logic [LIT_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/lzss_token_decoder.sv]
// Combinational bit-field extractor: aligns the pending bits, pulls out flag, literal,
// position and length, and gives the bits left once the token is dropped.
// Depends on lzss_pkg.
module lzss_token_decoder #(
  parameter int INDEX_BITS  = lzss_pkg::DEF_INDEX_BITS,
  parameter int LENGTH_BITS = lzss_pkg::DEF_LENGTH_BITS,
  localparam int PEND_W     = 1 + INDEX_BITS + LENGTH_BITS + 7,
  localparam int CNT_W      = $clog2(PEND_W + 1)
) (
  input  logic [PEND_W-1:0]             pending_bits,
  input  logic [CNT_W-1:0]              pending_count,
  output lzss_pkg::lzss_tok_t           tok,
  output logic [lzss_pkg::LIT_BITS-1:0] literal,
  output logic [INDEX_BITS-1:0]         pos,
  output logic [LENGTH_BITS-1:0]        len,
  output logic [PEND_W-1:0]             rest_bits,
  output logic [CNT_W-1:0]              rest_count
);
  import lzss_pkg::*;

  localparam logic [CNT_W-1:0] PEND_C  = CNT_W'(PEND_W);
  localparam logic [CNT_W-1:0] LIT_TOK = CNT_W'(1 + LIT_BITS);
  localparam logic [CNT_W-1:0] POS_TOK = CNT_W'(1 + INDEX_BITS);
  localparam logic [CNT_W-1:0] MAT_TOK = CNT_W'(1 + INDEX_BITS + LENGTH_BITS);

  logic [PEND_W-1:0] aligned;
  logic              flag;
  logic [CNT_W-1:0]  drop;

  // Oldest pending bit is moved up to the top of the word.
  assign aligned = pending_bits << (PEND_C - pending_count);
  assign flag    = aligned[PEND_W-1];
  assign literal = aligned[PEND_W-2 -: LIT_BITS];
  assign pos     = aligned[PEND_W-2 -: INDEX_BITS];
  assign len     = aligned[PEND_W-2-INDEX_BITS -: LENGTH_BITS];

  always_comb begin
    tok.lit_done   = flag && (pending_count >= LIT_TOK);
    tok.end_done   = !flag && (pending_count >= POS_TOK) &&
                     (pos == INDEX_BITS'(END_MARKER));
    tok.match_done = !flag && (pending_count >= MAT_TOK) &&
                     (pos != INDEX_BITS'(END_MARKER));
  end

  assign drop       = flag ? LIT_TOK : MAT_TOK;
  assign rest_count = pending_count - drop;
  assign rest_bits  = pending_bits & ~({PEND_W{1'b1}} << rest_count);

endmodule

[rtl/lzss_stream_decompressor_unit.sv]
// LZSS stream decompressor. A byte is accepted in the idle state and decoded in the decode
// state; a match of n (2 to 17) bytes then takes a window read and an emit state per copied
// byte, and the input is ready again only in idle. A byte after the end token is ignored in
// idle. A literal or end beat is registered from the decode state, a copied byte from the
// emit state; output stalls hold both. Synchronous reset clears the bit reader, sets the write
// position to one and clears the end flag; the window is not cleared and needs no sweep.
module lzss_stream_decompressor_unit #(
  parameter int INDEX_BITS  = lzss_pkg::DEF_INDEX_BITS,
  parameter int LENGTH_BITS = lzss_pkg::DEF_LENGTH_BITS
) (
  input logic      clk,
  input logic      rst,
  lzss_code_if.sink  code,
  lzss_data_if.source data
);
  import lzss_pkg::*;

  localparam int PEND_W = 1 + INDEX_BITS + LENGTH_BITS + 7;
  localparam int CNT_W  = $clog2(PEND_W + 1);
  localparam int CPY_W  = LENGTH_BITS + 1;

  lzss_state_t state;

  logic [PEND_W-1:0]     pending_bits;
  logic [CNT_W-1:0]      pending_count;
  logic [INDEX_BITS-1:0] write_position;
  logic                  finished;
  logic [INDEX_BITS-1:0] copy_pos;
  logic [CPY_W-1:0]      copy_cnt;

  logic                  out_valid;
  logic [LIT_BITS-1:0]   out_byte;
  logic                  out_last;
  logic                  out_end;

  lzss_tok_t             tok;
  logic [LIT_BITS-1:0]   tok_literal;
  logic [INDEX_BITS-1:0] tok_pos;
  logic [LENGTH_BITS-1:0] tok_len;
  logic [PEND_W-1:0]     rest_bits;
  logic [CNT_W-1:0]      rest_count;

  logic                  accept;
  logic                  slot_free;
  logic                  load_out;
  logic [PEND_W-1:0]     base_bits;
  logic [CNT_W-1:0]      base_count;
  logic                  base_finished;
  logic [INDEX_BITS-1:0] base_position;

  logic                  wr_en;
  logic [LIT_BITS-1:0]   wr_data;
  logic [LIT_BITS-1:0]   rd_data;

  lzss_token_decoder #(
    .INDEX_BITS (INDEX_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_decoder (
    .pending_bits (pending_bits),
    .pending_count(pending_count),
    .tok          (tok),
    .literal      (tok_literal),
    .pos          (tok_pos),
    .len          (tok_len),
    .rest_bits    (rest_bits),
    .rest_count   (rest_count)
  );

  lzss_window #(
    .INDEX_BITS(INDEX_BITS)
  ) u_window (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(write_position),
    .wr_data(wr_data),
    .rd_addr(copy_pos),
    .rd_data(rd_data)
  );

  assign code.ready       = (state == S_IDLE);
  assign accept           = code.valid && code.ready;
  assign slot_free        = !out_valid || data.ready;

  // The output register takes a new beat this cycle.
  assign load_out = slot_free &&
                    ((state == S_DECODE && (tok.lit_done || tok.end_done)) ||
                     (state == S_EMIT));

  assign data.valid       = out_valid;
  assign data.out_byte    = out_byte;
  assign data.last_of_run = out_last;
  assign data.stream_end  = out_end;

  // A new stream restarts the reader before the byte is appended.
  always_comb begin
    base_bits     = code.new_stream ? '0 : pending_bits;
    base_count    = code.new_stream ? '0 : pending_count;
    base_finished = code.new_stream ? 1'b0 : finished;
    base_position = code.new_stream ? INDEX_BITS'(1) : write_position;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_data = rd_data;
    if (state == S_DECODE && slot_free && tok.lit_done) begin
      wr_en   = 1'b1;
      wr_data = tok_literal;
    end else if (state == S_EMIT && slot_free) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      pending_bits   <= '0;
      pending_count  <= '0;
      write_position <= INDEX_BITS'(1);
      finished       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (data.ready && !load_out) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            write_position <= base_position;
            finished       <= base_finished;
            if (base_finished) begin
              pending_bits  <= base_bits;
              pending_count <= base_count;
            end else begin
              pending_bits  <= (base_bits << LIT_BITS) | PEND_W'(code.in_byte);
              pending_count <= base_count + CNT_W'(LIT_BITS);
              state         <= S_DECODE;
            end
          end
        end
        S_DECODE: begin
          if (tok.match_done) begin
            pending_bits  <= rest_bits;
            pending_count <= rest_count;
            copy_pos      <= tok_pos;
            copy_cnt      <= {1'b0, tok_len} + CPY_W'(MIN_MATCH_OFFSET);
            state         <= S_READ;
          end else if (tok.lit_done || tok.end_done) begin
            if (slot_free) begin
              out_valid <= 1'b1;
              out_last  <= 1'b1;
              if (tok.lit_done) begin
                pending_bits   <= rest_bits;
                pending_count  <= rest_count;
                write_position <= write_position + INDEX_BITS'(1);
                out_byte       <= tok_literal;
                out_end        <= 1'b0;
              end else begin
                // Bits left after the end token are thrown away.
                pending_bits  <= '0;
                pending_count <= '0;
                finished      <= 1'b1;
                out_byte      <= '0;
                out_end       <= 1'b1;
              end
              state <= S_IDLE;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid      <= 1'b1;
            out_byte       <= rd_data;
            out_last       <= (copy_cnt == '0);
            out_end        <= 1'b0;
            write_position <= write_position + INDEX_BITS'(1);
            copy_pos       <= copy_pos + INDEX_BITS'(1);
            copy_cnt       <= copy_cnt - CPY_W'(1);
            state          <= (copy_cnt == '0) ? S_IDLE : S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_finished_ignores: assert property (@(posedge clk) disable iff (rst)
    (accept && finished && !code.new_stream) |=> (state == S_IDLE))
    else $error("byte after end token was not ignored");

  a_copy_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && slot_free && copy_cnt == '0) |=>
      (state == S_IDLE && data.valid && data.last_of_run))
    else $error("final copied byte not flagged or sequencer did not stop");

  a_end_result: assert property (@(posedge clk) disable iff (rst)
    (data.valid && data.stream_end) |-> (data.out_byte == '0 && data.last_of_run))
    else $error("end-of-stream result carries data");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECODE && slot_free && tok.end_done) |=>
      (finished && pending_count == '0))
    else $error("end token did not clear the bit reader");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending_count <= CNT_W'(PEND_W))
    else $error("pending bit count overflow");

endmodule

[test/lzss_decode_checker.sv]
// Checker for the LZSS stream decompressor: watches both stream interfaces,
// decodes every accepted compressed beat itself and compares the plain beats.
// Depends on lzss_pkg and the interfaces in lzss_if.sv.
module lzss_decode_checker (
  input  logic clk,
  input  logic rst,
  lzss_code_if code,
  lzss_data_if data,
  output int   fail_count,
  output int   outstanding,
  output int   beats_checked
);
  import lzss_pkg::*;

  localparam int IDX_W     = DEF_INDEX_BITS;
  localparam int LEN_W     = DEF_LENGTH_BITS;
  localparam int WIN_DEPTH = 1 << IDX_W;

  typedef struct packed {
    logic [LIT_BITS-1:0] out_byte;
    logic                last_of_run;
    logic                stream_end;
  } plain_beat_t;

  plain_beat_t         plain_q[$];
  logic [23:0]         bit_buf;
  int                  bit_cnt;
  logic [7:0]          window [WIN_DEPTH];
  logic [IDX_W-1:0]    wr_pos;
  logic                ended;
  int                  fails = 0;
  int                  seen = 0;

  // The oldest unread bit sits at bit_cnt - 1.
  function automatic int unsigned peek(int skip, int n);
    return (bit_buf >> (bit_cnt - skip - n)) & ((1 << n) - 1);
  endfunction

  task automatic drop(int n);
    bit_cnt -= n;
    bit_buf &= 24'((32'd1 << bit_cnt) - 32'd1);
  endtask

  task automatic emit_plain(logic [7:0] c, logic last);
    plain_q.push_back('{out_byte: c, last_of_run: last, stream_end: 1'b0});
    window[wr_pos] = c;
    wr_pos = wr_pos + 1'b1;
  endtask

  task automatic decode_byte(logic [7:0] b, logic restart);
    int unsigned pos;
    int unsigned len;
    if (restart) begin
      bit_buf = '0;
      bit_cnt = 0;
      wr_pos  = 1;
      ended   = 1'b0;
    end
    if (ended) return;
    bit_buf = {bit_buf[15:0], b};
    bit_cnt += 8;
    if (bit_buf[bit_cnt-1]) begin
      if (bit_cnt < 1 + LIT_BITS) return;
      pos = peek(1, LIT_BITS);
      drop(1 + LIT_BITS);
      emit_plain(pos[7:0], 1'b1);
    end else begin
      if (bit_cnt < 1 + IDX_W) return;
      pos = peek(1, IDX_W);
      if (pos == END_MARKER) begin
        ended   = 1'b1;
        bit_buf = '0;
        bit_cnt = 0;
        plain_q.push_back('{out_byte: '0, last_of_run: 1'b1, stream_end: 1'b1});
      end else begin
        if (bit_cnt < 1 + IDX_W + LEN_W) return;
        len = peek(1 + IDX_W, LEN_W) + MIN_MATCH_OFFSET + 1;
        drop(1 + IDX_W + LEN_W);
        // Each copied byte lands in the window before the next read, so an
        // overlapping copy repeats what it has just written.
        for (int i = 0; i < len; i++) begin
          emit_plain(window[(pos + i) % WIN_DEPTH], i == len - 1);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    plain_beat_t want;
    plain_beat_t got;
    if (rst) begin
      bit_buf = '0;
      bit_cnt = 0;
      wr_pos  = 1;
      ended   = 1'b0;
      plain_q.delete();
    end else begin
      if (data.valid && data.ready) begin
        seen++;
        got = '{out_byte: data.out_byte, last_of_run: data.last_of_run,
                stream_end: data.stream_end};
        if (plain_q.size() == 0) begin
          fails++;
          $error("unexpected beat: out_byte %02h last_of_run %0b stream_end %0b",
                 got.out_byte, got.last_of_run, got.stream_end);
        end else begin
          want = plain_q.pop_front();
          if (got.out_byte !== want.out_byte) begin
            fails++;
            $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
          end
          if (got.last_of_run !== want.last_of_run) begin
            fails++;
            $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
          end
          if (got.stream_end !== want.stream_end) begin
            fails++;
            $error("stream_end: expected %0b, got %0b", want.stream_end, got.stream_end);
          end
        end
      end
      if (code.valid && code.ready) decode_byte(code.in_byte, code.new_stream);
    end
    fail_count    <= fails;
    beats_checked <= seen;
    outstanding   <= plain_q.size();
  end

endmodule

[test/lzss_stream_decompressor_unit_test.sv]
// Top of the LZSS decompressor test: builds compressed streams token by token,
// drives them under three handshake pressure settings and gives the verdict.
// Depends on lzss_pkg, lzss_if.sv, the block and lzss_decode_checker.
module lzss_stream_decompressor_unit_test;
  import lzss_pkg::*;

  localparam int IDX_W      = DEF_INDEX_BITS;
  localparam int LEN_W      = DEF_LENGTH_BITS;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 40;

  typedef struct packed {
    logic [LIT_BITS-1:0] in_byte;
    logic                new_stream;
  } code_beat_t;

  logic clk;
  logic rst;

  lzss_code_if code_ch ();
  lzss_data_if data_ch ();

  int fail_count;
  int outstanding;
  int beats_checked;

  lzss_stream_decompressor_unit u_top (
    .clk  (clk),
    .rst  (rst),
    .code (code_ch),
    .data (data_ch)
  );

  lzss_decode_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .code          (code_ch),
    .data          (data_ch),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .beats_checked (beats_checked)
  );

  code_beat_t       stim_q[$];
  logic [31:0]      pack_acc;
  int               pack_cnt;
  logic             ns_next;
  // Which window entries the streams built so far will have written.
  bit               window_filled [1 << IDX_W];
  logic [IDX_W-1:0] fill_pos;
  int               items_sent;
  int               ignored_sent;
  int               streams_sent;
  int               send_idle;
  int               recv_idle;
  int               stall_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) data_ch.ready <= 1'b0;
    else data_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst || (code_ch.valid && code_ch.ready) || (data_ch.valid && data_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic queue_byte(logic [7:0] b, bit counts);
    stim_q.push_back('{in_byte: b, new_stream: ns_next});
    ns_next = 1'b0;
    if (counts) items_sent++;
    else ignored_sent++;
  endtask

  task automatic put_bits(int unsigned val, int n);
    pack_acc = (pack_acc << n) | val;
    pack_cnt += n;
    while (pack_cnt >= 8) begin
      queue_byte(pack_acc[pack_cnt-1 -: 8], 1'b1);
      pack_cnt -= 8;
    end
  endtask

  task automatic pad_byte();
    int n;
    n = 8 - pack_cnt;
    if (pack_cnt > 0) put_bits($urandom_range((1 << n) - 1), n);
  endtask

  task automatic start_stream();
    pack_acc = '0;
    pack_cnt = 0;
    ns_next  = 1'b1;
    fill_pos = 1;
    streams_sent++;
  endtask

  task automatic put_literal(logic [7:0] c);
    put_bits({1'b1, c}, 1 + LIT_BITS);
    window_filled[fill_pos] = 1'b1;
    fill_pos = fill_pos + 1'b1;
  endtask

  task automatic put_match(logic [IDX_W-1:0] pos, logic [LEN_W-1:0] raw);
    put_bits({1'b0, pos, raw}, 1 + IDX_W + LEN_W);
    for (int i = 0; i < int'(raw) + MIN_MATCH_OFFSET + 1; i++) begin
      window_filled[fill_pos] = 1'b1;
      fill_pos = fill_pos + 1'b1;
    end
  endtask

  // Bits after the end token and the garbage bytes that follow are ignored.
  task automatic close_with_end(int garbage);
    put_bits(END_MARKER, 1 + IDX_W);
    pad_byte();
    repeat (garbage) queue_byte(8'($urandom), 1'b0);
  endtask

  // The last full token completes; the bits after it never make a whole token.
  task automatic close_broken();
    if (pack_cnt > 0) pad_byte();
    else queue_byte(8'($urandom), 1'b1);
  endtask

  // A copy may only read entries already written, counting its own writes.
  function automatic bit match_ok(logic [IDX_W-1:0] pos, int count);
    logic [IDX_W-1:0] src;
    for (int i = 0; i < count; i++) begin
      src = pos + IDX_W'(i);
      if (!window_filled[src] && int'(IDX_W'(src - fill_pos)) >= i) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic random_token();
    logic [IDX_W-1:0] pos;
    logic [LEN_W-1:0] raw;
    bit               placed;
    placed = 1'b0;
    if ($urandom_range(99) >= 40) begin
      raw = LEN_W'($urandom);
      for (int t = 0; t < 8 && !placed; t++) begin
        if ($urandom_range(1) == 1) pos = fill_pos - IDX_W'($urandom_range(1, 24));
        else pos = IDX_W'($urandom_range(1, (1 << IDX_W) - 1));
        if (pos != END_MARKER && match_ok(pos, int'(raw) + MIN_MATCH_OFFSET + 1)) begin
          put_match(pos, raw);
          placed = 1'b1;
        end
      end
    end
    if (!placed) put_literal(8'($urandom));
  endtask

  task automatic random_stream();
    int n;
    start_stream();
    if ($urandom_range(99) < 5) begin
      queue_byte(8'($urandom), 1'b1);
    end else begin
      n = ($urandom_range(9) == 0) ? $urandom_range(6, 30) : $urandom_range(1, 5);
      repeat (n) random_token();
      if ($urandom_range(99) < 80) close_with_end(($urandom_range(2) == 0) ? $urandom_range(1, 2) : 0);
      else close_broken();
    end
  endtask

  task automatic directed_part();
    // Literals at both byte extremes, a shortest copy, then a longest one that
    // overlaps its own output.
    start_stream();
    put_literal(8'h00);
    put_literal(8'hFF);
    put_literal(8'h5A);
    put_match(1, 0);
    put_match(5, 15);
    close_with_end(2);
    // A stream cut short part-way through a token.
    start_stream();
    put_literal(8'hA5);
    put_match(1, 7);
    put_match(3, 15);
    close_broken();
    // A lone byte after a restart can never complete a token.
    start_stream();
    queue_byte(8'($urandom), 1'b1);
    // End token as the very first token of a stream.
    start_stream();
    close_with_end(1);
  endtask

  task automatic send_queued();
    while (stim_q.size() != 0) begin
      if ($urandom_range(99) < send_idle) begin
        code_ch.valid <= 1'b0;
        @(posedge clk);
      end else begin
        code_ch.valid      <= 1'b1;
        code_ch.in_byte    <= stim_q[0].in_byte;
        code_ch.new_stream <= stim_q[0].new_stream;
        @(posedge clk);
        while (!code_ch.ready) @(posedge clk);
        stim_q.delete(0);
      end
    end
  endtask

  task automatic wait_drained();
    code_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic run_phase(int target);
    while (items_sent < target) begin
      random_stream();
      send_queued();
      if ($urandom_range(19) == 0) wait_drained();
    end
  endtask

  initial begin
    rst                <= 1'b1;
    code_ch.valid      <= 1'b0;
    code_ch.in_byte    <= '0;
    code_ch.new_stream <= 1'b0;
    items_sent         = 0;
    ignored_sent       = 0;
    streams_sent       = 0;
    send_idle          = 6;
    recv_idle          = 81;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    directed_part();
    send_queued();
    run_phase(125);
    wait_drained();

    send_idle = 81;
    recv_idle = 6;
    run_phase(250);
    wait_drained();

    send_idle = 0;
    recv_idle = 0;
    run_phase(370);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d compressed bytes over %0d streams plus %0d bytes after end tokens,",
             items_sent, streams_sent, ignored_sent);
    $display("with %0d decompressed beats compared under three handshake pressure settings.",
             beats_checked);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[lzss_stream_decompressor_unit.f]
rtl/lzss_pkg.sv
rtl/lzss_if.sv
rtl/lzss_window.sv
rtl/lzss_token_decoder.sv
rtl/lzss_stream_decompressor_unit.sv
test/lzss_decode_checker.sv
test/lzss_stream_decompressor_unit_test.sv
